>>> src/stfms_pkg.sv
// Shared constants, types and control struct for the sorted table search block.
package stfms_pkg;

  // Table size and key width
  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 16;

  // Fixed field widths of the channels
  localparam int OP_W  = 2;
  localparam int KEY_W = 16;
  localparam int STS_W = 2;
  localparam int POS_W = 11;

  // Fill count and scan counter width, able to hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Opcodes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STS_W-1:0] STS_FOUND   = 2'd0;
  localparam logic [STS_W-1:0] STS_MISSING = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic                ins;    // place key in sorted position
    logic                load;   // capture compare flags against key
    logic                shift;  // move compare flags one cell toward the head
    logic [KEY_BITS-1:0] key;
    logic [CNT_W-1:0]    count;  // number of occupied cells
  } stfms_ctl_t;

endpackage

>>> src/stfms_if.sv
// Valid/ready channel interfaces for input items and result items.
interface stfms_in_if;
  import stfms_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface stfms_out_if;
  import stfms_pkg::*;
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [KEY_W-1:0] echo_key;
  logic [POS_W-1:0] position;

  modport source (output valid, output status, output echo_key, output position, input ready);
  modport sink   (input valid, input status, input echo_key, input position, output ready);
endinterface

>>> src/sorted_table_first_match_search.sv
// Top level: sorted key table with first-match search over a cell chain.
//
// Input channel in_ch carries an opcode and a key: clear, insert or query.
// Result channel out_ch carries status, echo_key and position.
// Clear and a successful insert give no result; the insert is done by
// every cell shifting in parallel. An insert into a full table gives a
// full status beat through the pending register and the output register.
// A query captures compare flags in all cells, then shifts them toward the
// head one cell a cycle while counting smaller keys; the walk of the flags
// along the chain sets how long a query waits for its result beat.
// One item is worked on at a time; in_ch.ready is high whenever the
// controller is idle and out of reset, also while a finished result waits
// in the output register. A stalled receiver holds the result beat; a later
// result waits in a pending register until the output register frees.
// Reset empties the table at once (fill count to zero); no clearing pass.
module sorted_table_first_match_search
  import stfms_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  stfms_in_if.sink      in_ch,
  stfms_out_if.source   out_ch
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [STS_W-1:0] res_status_r, res_status_nxt;
  logic [KEY_W-1:0] res_key_r, res_key_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [STS_W-1:0] out_status_r, out_status_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic             in_fire;
  logic [KEY_W-1:0] in_key_m;
  stfms_ctl_t       ctl;
  logic             head_lt;
  logic             head_eq;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_key_m = KEY_W'(in_ch.key[KEY_BITS-1:0]);

  stfms_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .head_lt (head_lt),
    .head_eq (head_eq)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  // Next state, chain commands and result handling
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_pos_nxt    = out_pos_r;
    ctl.ins        = 1'b0;
    ctl.load       = 1'b0;
    ctl.shift      = 1'b0;
    ctl.key        = in_ch.key[KEY_BITS-1:0];
    ctl.count      = count_r;
    in_ch.ready    = rst_n && (state_r == ST_IDLE);

    // Drop the output beat once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_INSERT: begin
              if (count_r != CNT_W'(CAPACITY)) begin
                ctl.ins   = 1'b1;
                count_nxt = count_r + 1'b1;
              end else begin
                res_status_nxt = STS_FULL;
                res_key_nxt    = in_key_m;
                res_pos_nxt    = '0;
                state_nxt      = ST_RESP;
              end
            end
            OP_QUERY: begin
              ctl.load    = 1'b1;
              res_key_nxt = in_key_m;
              scan_nxt    = '0;
              state_nxt   = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Count smaller keys leaving the head; stop at the first other one
        if (head_lt) begin
          ctl.shift = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end else begin
          res_status_nxt = head_eq ? STS_FOUND : STS_MISSING;
          res_pos_nxt    = head_eq ? POS_W'(scan_r + 1'b1) : '0;
          state_nxt      = ST_RESP;
        end
      end
      ST_RESP: begin
        // Advance the pending result into a free output register
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_pos_nxt    = res_pos_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.echo_key = out_key_r;
  assign out_ch.position = out_pos_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.opcode == OP_INSERT) && (count_r != CNT_W'(CAPACITY))
    |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted insert did not grow the table");

  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.opcode == OP_QUERY) |=> state_r == ST_SCAN)
    else $error("accepted query did not start a scan");

  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == STS_FOUND) |-> out_pos_r != '0)
    else $error("found result with zero position");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> scan_r <= count_r)
    else $error("scan ran past the stored keys");
`endif

endmodule

>>> src/stfms_cell.sv
// One table cell: holds a key, shifts on insert, and carries compare flags.
module stfms_cell
  import stfms_pkg::*;
(
  input  logic                clk,
  input  stfms_ctl_t          ctl,
  input  logic                occupied,   // cell index below fill count
  input  logic                tail,       // cell index equals fill count
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                left_gt,
  input  logic                right_lt,
  input  logic                right_eq,
  output logic [KEY_BITS-1:0] key_o,
  output logic                gt_o,
  output logic                lt_o,
  output logic                eq_o
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                lt_r, lt_nxt;
  logic                eq_r, eq_nxt;
  logic                gt;

  // Stored key above the broadcast key
  assign gt = occupied && (key_r > ctl.key);

  // Take the left neighbor's key or the new key on insert, else hold
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (left_gt) begin
        key_nxt = left_key;
      end else if (gt || tail) begin
        key_nxt = ctl.key;
      end
    end
  end

  // Capture compare flags, or hand them toward the head
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (ctl.load) begin
      lt_nxt = occupied && (key_r < ctl.key);
      eq_nxt = occupied && (key_r == ctl.key);
    end else if (ctl.shift) begin
      lt_nxt = right_lt;
      eq_nxt = right_eq;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

  assign key_o = key_r;
  assign gt_o  = gt;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule

>>> src/stfms_chain.sv
// Row of CAPACITY cells linked to their neighbors; flags leave at the head.
module stfms_chain
  import stfms_pkg::*;
(
  input  logic       clk,
  input  stfms_ctl_t ctl,
  output logic       head_lt,
  output logic       head_eq
);

  logic [KEY_BITS-1:0] key_w [CAPACITY];
  logic [CAPACITY-1:0] gt_w;
  logic [CAPACITY-1:0] lt_w;
  logic [CAPACITY-1:0] eq_w;

  // Build the row; the head has no left neighbor, the end has no right one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] lkey;
    logic                lgt;
    logic                rlt;
    logic                req;

    if (i == 0) begin : g_head
      assign lkey = '0;
      assign lgt  = 1'b0;
    end else begin : g_mid
      assign lkey = key_w[i-1];
      assign lgt  = gt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign rlt = 1'b0;
      assign req = 1'b0;
    end else begin : g_link
      assign rlt = lt_w[i+1];
      assign req = eq_w[i+1];
    end

    stfms_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (ctl.count > CNT_W'(i)),
      .tail     (ctl.count == CNT_W'(i)),
      .left_key (lkey),
      .left_gt  (lgt),
      .right_lt (rlt),
      .right_eq (req),
      .key_o    (key_w[i]),
      .gt_o     (gt_w[i]),
      .lt_o     (lt_w[i]),
      .eq_o     (eq_w[i])
    );
  end

  assign head_lt = lt_w[0];
  assign head_eq = eq_w[0];

endmodule

>>> test/testbench.sv
// Self-checking testbench for the sorted key table with first-match search.
module testbench;
  import stfms_pkg::*;

  // Opcode value that the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_BITS) - 1);
  // Keep random tables short so queries stay quick
  localparam int TABLE_SOFT_MAX = 96;
  localparam int RUN_LIMIT      = 1_000_000;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [KEY_W-1:0] echo_key;
    logic [POS_W-1:0] position;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;

  stfms_in_if  in_ch();
  stfms_out_if out_ch();

  sorted_table_first_match_search u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted contents of the table, ascending
  logic [KEY_W-1:0] table_keys[$];
  answer_t          awaited_answers[$];

  int  fail_count    = 0;
  int  cycle_count   = 0;
  bit  send_idle_on  = 1'b1;
  bit  recv_idle_on  = 1'b1;
  int  recv_hold_req = 0;

  int n_clears = 0, n_stored = 0, n_rejected = 0, n_ignored = 0;
  int n_found = 0, n_missing = 0, n_in_stalls = 0, max_fill = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Count stored keys below k, or at most k when inclusive
  function automatic int keys_below(input logic [KEY_W-1:0] k, input bit inclusive);
    int n;
    n = 0;
    foreach (table_keys[i]) begin
      if (table_keys[i] < k || (inclusive && table_keys[i] == k)) n++;
    end
    return n;
  endfunction

  // Apply one accepted beat to the predicted table and queue its answer
  function automatic void predict_table_step(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] k;
    int      at;
    answer_t ans;
    k = raw_key & KEY_MASK;
    ans.echo_key = k;
    ans.position = '0;
    case (op)
      OP_CLEAR: begin
        table_keys.delete();
        n_clears++;
      end
      OP_INSERT: begin
        if (table_keys.size() >= CAPACITY) begin
          ans.status = STS_FULL;
          awaited_answers.push_back(ans);
          n_rejected++;
        end else begin
          // equal keys: the new one goes after the existing ones
          at = keys_below(k, 1'b1);
          if (at >= table_keys.size()) table_keys.push_back(k);
          else table_keys.insert(at, k);
          n_stored++;
          if (table_keys.size() > max_fill) max_fill = table_keys.size();
        end
      end
      OP_QUERY: begin
        at = keys_below(k, 1'b0);
        if (at < table_keys.size() && table_keys[at] == k) begin
          ans.status   = STS_FOUND;
          ans.position = POS_W'(at + 1);
          n_found++;
        end else begin
          ans.status = STS_MISSING;
          n_missing++;
        end
        awaited_answers.push_back(ans);
      end
      default: n_ignored++;
    endcase
  endfunction

  // Offer one beat, with an optional idle burst first, and predict it on acceptance
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    int gap;
    gap = (send_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key    <= k;
    @(posedge clk);
    while (!in_ch.ready) begin
      n_in_stalls++;
      @(posedge clk);
    end
    predict_table_step(op, k);
  endtask

  // Drop valid and hold until every queued answer has come back
  task automatic wait_for_all_answers();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return KEY_W'($urandom_range(0, 15));
      1:       return KEY_W'($urandom_range(16'hFFF0, 16'hFFFF));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Mostly stored keys and their neighbors, so queries hit
  function automatic logic [KEY_W-1:0] pick_query_key();
    logic [KEY_W-1:0] k;
    if (table_keys.size() == 0) return pick_key();
    k = table_keys[$urandom_range(0, table_keys.size() - 1)];
    case ($urandom_range(0, 3))
      0:       return k + 1'b1;
      1:       return pick_key();
      default: return k;
    endcase
  endfunction

  // Receiver: random stalls plus long hold-offs on request
  initial begin : answer_receiver
    int stall_left;
    int hold_left;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_req > 0) begin
        hold_left     = recv_hold_req;
        recv_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest predicted answer
  always @(posedge clk) begin : answer_checker
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_answers.size() == 0) begin
        $error("result beat with no answer pending: status %0d key %h position %0d",
               out_ch.status, out_ch.echo_key, out_ch.position);
        fail_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.echo_key !== want.echo_key) begin
          $error("echo_key: expected %h, got %h", want.echo_key, out_ch.echo_key);
          fail_count++;
        end
        if (out_ch.position !== want.position) begin
          $error("position: expected %0d, got %0d (key %h)",
                 want.position, out_ch.position, want.echo_key);
          fail_count++;
        end
      end
    end
  end

  // Extreme keys, duplicates, empty table, query above every key, unused opcode
  task automatic test_directed();
    send_item(OP_QUERY,  16'h0000);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'h8000);
    send_item(OP_INSERT, 16'h5555);
    send_item(OP_INSERT, 16'hAAAA);
    send_item(OP_QUERY,  16'h8000);
    send_item(OP_QUERY,  16'h0000);
    send_item(OP_QUERY,  16'hFFFF);
    send_item(OP_QUERY,  16'h7FFF);
    send_item(OP_QUERY,  16'h0003);
    send_item(OP_UNUSED, 16'h1234);
    send_item(OP_QUERY,  16'h1234);
    send_item(OP_CLEAR,  16'h0000);
    send_item(OP_QUERY,  16'h8000);
    send_item(OP_INSERT, 16'h0001);
    send_item(OP_QUERY,  16'h0002);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_QUERY,  16'h0001);
    send_item(OP_CLEAR,  16'hFFFF);
    send_item(OP_QUERY,  16'h0001);
  endtask

  // Fill to capacity, reject further inserts, search the full table
  task automatic test_full_table();
    logic [KEY_W-1:0] k;
    send_item(OP_CLEAR, 16'h0000);
    send_item(OP_INSERT, 16'h0000);
    for (int i = 0; i < CAPACITY - 2; i++) begin
      if (i % 16 == 5) k = table_keys[$urandom_range(0, table_keys.size() - 1)];
      else k = KEY_W'($urandom_range(0, 16'hFFFD));
      send_item(OP_INSERT, k);
    end
    // unique largest key lands at the last position
    send_item(OP_INSERT, 16'hFFFE);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_QUERY,  16'hFFFE);
    send_item(OP_QUERY,  16'hFFFF);
    send_item(OP_QUERY,  16'h0000);
    repeat (3) send_item(OP_QUERY, pick_query_key());
    send_item(OP_INSERT, pick_key());
    send_item(OP_CLEAR,  16'h0000);
    send_item(OP_QUERY,  16'hFFFE);
    send_item(OP_INSERT, 16'h4321);
    send_item(OP_QUERY,  16'h4321);
    wait_for_all_answers();
  endtask

  // Hold the receiver off so the block fills and stalls its input
  task automatic test_backpressure();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    send_item(OP_CLEAR, 16'h0000);
    repeat (8) send_item(OP_INSERT, pick_key());
    recv_hold_req = 300;
    repeat (30) begin
      if ($urandom_range(0, 3) == 0) send_item(OP_INSERT, pick_key());
      else send_item(OP_QUERY, pick_query_key());
    end
    wait_for_all_answers();
    send_idle_on = 1'b1;
    repeat (20) send_item(OP_QUERY, pick_query_key());
    wait_for_all_answers();
  endtask

  // Well-formed episodes of inserts and queries, with some raw noise
  task automatic run_random_items(input int target, input bit quiet);
    int               sent;
    logic [OP_W-1:0]  op;
    sent = 0;
    while (sent < target) begin
      send_idle_on = !quiet && $urandom_range(0, 3) != 0;
      recv_idle_on = !quiet && $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(2, 8)) begin
          op = OP_W'($urandom_range(0, 3));
          send_item(op, KEY_W'($urandom));
          if (op != OP_UNUSED) sent++;
        end
      end else begin
        if ($urandom_range(0, 3) != 0 || table_keys.size() > 80) begin
          send_item(OP_CLEAR, KEY_W'($urandom));
          sent++;
        end
        repeat ($urandom_range(4, 40)) begin
          if (table_keys.size() < TABLE_SOFT_MAX && $urandom_range(0, 1) == 0)
            send_item(OP_INSERT, pick_key());
          else
            send_item(OP_QUERY, pick_query_key());
          sent++;
        end
      end
    end
  endtask

  task automatic test_random();
    run_random_items(600, 1'b0);
  endtask

  // Final stretch at full rate on both sides
  task automatic test_quiet_tail();
    run_random_items(80, 1'b1);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_CLEAR;
    in_ch.key    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_table();
    test_backpressure();
    test_random();
    test_quiet_tail();

    // Drain, then watch for stray beats for the longest query time
    wait_for_all_answers();
    repeat (CAPACITY + 16) @(posedge clk);

    $display("Covered %0d clears, %0d stored inserts, %0d full rejects, %0d ignored beats.",
             n_clears, n_stored, n_rejected, n_ignored);
    $display("Queries: %0d found, %0d missing; largest table %0d keys; %0d input stall cycles.",
             n_found, n_missing, max_fill, n_in_stalls);
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
